@@ hw/rtl/framebuffer_wrap_scroll_assert.svh @@
// ----------------------------------------------------------------------------
// framebuffer_wrap_scroll_assert.svh
// Assertion macros shared by the scroll block RTL.
// ----------------------------------------------------------------------------
`ifndef FRAMEBUFFER_WRAP_SCROLL_ASSERT_SVH
`define FRAMEBUFFER_WRAP_SCROLL_ASSERT_SVH

// Condition that holds at every clock edge out of reset.
`define FWS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// Antecedent implies consequent in the same cycle.
`define FWS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/fws_pkg.sv @@
// ----------------------------------------------------------------------------
// fws_pkg
// Geometry constants, register codes and address helper for the scroll block.
// ----------------------------------------------------------------------------
package fws_pkg;

  // Frame geometry
  localparam int ROW_BYTES   = 52;
  localparam int FRAME_ROWS  = 240;
  localparam int ROW_PIXELS  = 400;
  localparam int VIS_BYTES   = ROW_PIXELS / 8;
  localparam int FRAME_DEPTH = ROW_BYTES * FRAME_ROWS;

  // Scroll limits
  localparam int H_LIMIT = 400;
  localparam int V_LIMIT = 240;

  // Widths
  localparam int ADDR_W   = $clog2(FRAME_DEPTH);
  localparam int ROW_W    = 8;
  localparam int COL_W    = 6;
  localparam int BYTE_W   = 8;
  localparam int HMOD_W   = $clog2(ROW_PIXELS);
  localparam int VMOD_W   = $clog2(FRAME_ROWS);
  localparam int CFG_W    = 10;
  localparam int CFGIDX_W = 1;

  // Register indexes
  localparam logic [CFGIDX_W-1:0] CFG_H_SHIFT = 1'b0;
  localparam logic [CFGIDX_W-1:0] CFG_V_SHIFT = 1'b1;

  // Item actions
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_READ = 1'b1;

  // Linear frame address of a byte
  function automatic logic [ADDR_W-1:0] frame_addr(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
    logic [ADDR_W-1:0] base;
    base = ADDR_W'(row) * ADDR_W'(ROW_BYTES);
    return base + ADDR_W'(col);
  endfunction

endpackage

@@ hw/rtl/fws_frame_ram.sv @@
// ----------------------------------------------------------------------------
// fws_frame_ram
// Single-port synchronous RAM with registered read; read data holds
// while no read is issued.
// ----------------------------------------------------------------------------
module fws_frame_ram #(
  parameter int DEPTH  = 12480,
  parameter int WIDTH  = 8,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  // Registered read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/framebuffer_wrap_scroll.sv @@
// ----------------------------------------------------------------------------
// framebuffer_wrap_scroll
// 1bpp frame store with toroidal horizontal and vertical scroll on read.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------
//  cfg     | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//  in      | in        | in_valid_i/in_ready_o   | action, row_index, column_byte,
//          |           |                         | load_byte
//  out     | out       | out_valid_o/out_ready_i | scrolled_byte
//
// Load beat: accept, then the memory write. Read beat: accept, issue the
// read, then finish; when the scrolled byte straddles two source bytes a
// second read follows the issue; both reads share the single frame RAM port.
// Reset clears control and scroll registers only; frame RAM is not cleared.
// A finished result waits in the output register; a new beat is accepted
// meanwhile, and a second read stalls only in its last cycle until out drains.
// ----------------------------------------------------------------------------
module framebuffer_wrap_scroll (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [fws_pkg::CFGIDX_W-1:0]   cfg_index_i,
  input  logic [fws_pkg::CFG_W-1:0]      cfg_data_i,
  // input items
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           action_i,
  input  logic [fws_pkg::ROW_W-1:0]      row_index_i,
  input  logic [fws_pkg::COL_W-1:0]      column_byte_i,
  input  logic [fws_pkg::BYTE_W-1:0]     load_byte_i,
  // results
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [fws_pkg::BYTE_W-1:0]     scrolled_byte_o
);

  import fws_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_SECOND, ST_FINISH} state_e;
  typedef enum logic [2:0] {OP_LOAD, OP_SKIP, OP_ZERO, OP_SINGLE, OP_PAIR} op_e;

  state_e state_q;
  op_e    op_q, op_d;

  logic [HMOD_W-1:0] h_mod_q;
  logic              h_zero_q;
  logic [VMOD_W-1:0] v_mod_q;

  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  idx0_q, idx0_d, idx1_q;
  logic [2:0]        off_q;
  logic [BYTE_W-1:0] data_q, b0_q;
  logic              out_valid_q;
  logic [BYTE_W-1:0] out_byte_q;

  // ---------------------------------------------------------------------------
  // Scroll registers: saturate, then keep the wrapped shift
  // ---------------------------------------------------------------------------
  logic signed [CFG_W-1:0]   h_raw;
  logic signed [CFG_W-2:0]   v_raw;
  logic        [HMOD_W-1:0]  h_mod_d;
  logic        [VMOD_W-1:0]  v_mod_d;

  assign cfg_ready_o = 1'b1;
  assign h_raw = cfg_data_i;
  assign v_raw = cfg_data_i[CFG_W-2:0];

  always_comb begin
    // at or beyond the limit the shift wraps to zero
    if (h_raw >= 0) begin
      h_mod_d = (h_raw >= CFG_W'(H_LIMIT)) ? '0 : h_raw[HMOD_W-1:0];
    end else if (h_raw <= -CFG_W'(H_LIMIT)) begin
      h_mod_d = '0;
    end else begin
      h_mod_d = HMOD_W'(h_raw + CFG_W'(ROW_PIXELS));
    end
    if (v_raw >= 0) begin
      v_mod_d = (v_raw >= 9'sd240) ? '0 : v_raw[VMOD_W-1:0];
    end else if (v_raw <= -9'sd240) begin
      v_mod_d = '0;
    end else begin
      v_mod_d = VMOD_W'(v_raw + 9'sd240);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_mod_q  <= '0;
      h_zero_q <= 1'b1;
      v_mod_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_H_SHIFT: begin
          h_mod_q  <= h_mod_d;
          h_zero_q <= (h_raw == '0);
        end
        CFG_V_SHIFT: v_mod_q <= v_mod_d;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Item decode at accept: source row, source pixel and byte pair
  // ---------------------------------------------------------------------------
  logic              in_fire;
  logic              item_ok;
  logic [ROW_W:0]    row_diff;
  logic [ROW_W-1:0]  src_row;
  logic [HMOD_W:0]   pix_diff;
  logic [HMOD_W-1:0] src_pix;
  logic [COL_W-1:0]  src_col, next_byte;
  logic [2:0]        src_off;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign item_ok    = (row_index_i < ROW_W'(FRAME_ROWS)) &&
                      (column_byte_i < COL_W'(ROW_BYTES));

  assign row_diff = {1'b0, row_index_i} - {1'b0, v_mod_q};
  assign src_row  = row_diff[ROW_W] ? (row_diff[ROW_W-1:0] + ROW_W'(FRAME_ROWS))
                                    : row_diff[ROW_W-1:0];

  assign pix_diff = {1'b0, column_byte_i, 3'b000} - {1'b0, h_mod_q};
  assign src_pix  = pix_diff[HMOD_W] ? (pix_diff[HMOD_W-1:0] + HMOD_W'(ROW_PIXELS))
                                     : pix_diff[HMOD_W-1:0];
  assign src_col   = src_pix[HMOD_W-1:3];
  assign src_off   = src_pix[2:0];
  // right neighbor wraps at the last visible byte
  assign next_byte = (src_col == COL_W'(VIS_BYTES - 1)) ? '0 : src_col + 1'b1;

  always_comb begin
    row_d  = row_index_i;
    idx0_d = column_byte_i;
    if (action_i == ACT_LOAD) begin
      op_d = item_ok ? OP_LOAD : OP_SKIP;
    end else if (!item_ok) begin
      op_d = OP_ZERO;
    end else if (h_zero_q) begin
      op_d  = OP_SINGLE;
      row_d = src_row;
    end else if (column_byte_i >= COL_W'(VIS_BYTES)) begin
      // padding comes from the requested row, unscrolled
      op_d = OP_SINGLE;
    end else begin
      row_d  = src_row;
      idx0_d = src_col;
      op_d   = (src_off == 3'd0) ? OP_SINGLE : OP_PAIR;
    end
  end

  // ---------------------------------------------------------------------------
  // Frame RAM
  // ---------------------------------------------------------------------------
  logic              ram_we, ram_re;
  logic [COL_W-1:0]  ram_col;
  logic [ADDR_W-1:0] ram_addr;
  logic [BYTE_W-1:0] ram_rdata;

  assign ram_we   = (state_q == ST_ISSUE) && (op_q == OP_LOAD);
  assign ram_re   = ((state_q == ST_ISSUE) && ((op_q == OP_SINGLE) || (op_q == OP_PAIR))) ||
                    (state_q == ST_SECOND);
  assign ram_col  = (state_q == ST_SECOND) ? idx1_q : idx0_q;
  assign ram_addr = frame_addr(row_q, ram_col);

  fws_frame_ram #(
    .DEPTH (FRAME_DEPTH),
    .WIDTH (BYTE_W)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (data_q),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Result assembly
  // ---------------------------------------------------------------------------
  logic [2*BYTE_W-1:0] pair_word;
  logic [BYTE_W-1:0]   result;
  logic                out_free;

  assign pair_word = {b0_q, ram_rdata} << off_q;
  assign out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    case (op_q)
      OP_SINGLE: result = ram_rdata;
      OP_PAIR:   result = pair_word[2*BYTE_W-1:BYTE_W];
      default:   result = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Item payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q   <= op_d;
      row_q  <= row_d;
      idx0_q <= idx0_d;
      idx1_q <= next_byte;
      off_q  <= src_off;
      data_q <= load_byte_i;
    end
    if (state_q == ST_SECOND) begin
      b0_q <= ram_rdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer and output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_byte_q  <= '0;
    end else begin
      // drain the output slot; a result finishing now refills it below
      if (out_valid_q && out_ready_i && (state_q != ST_FINISH)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            state_q <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          unique case (op_q) inside
            OP_LOAD, OP_SKIP:   state_q <= ST_IDLE;
            OP_ZERO, OP_SINGLE: state_q <= ST_FINISH;
            OP_PAIR:            state_q <= ST_SECOND;
            default:            state_q <= ST_IDLE;
          endcase
        end
        ST_SECOND: state_q <= ST_FINISH;
        ST_FINISH: begin
          // RAM read data holds while the output slot is busy
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_byte_q  <= result;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign scrolled_byte_o = out_byte_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  logic shift_ok;
  logic in_finish;
  logic in_second;
  logic issue_pair;

  assign shift_ok   = (h_mod_q < HMOD_W'(ROW_PIXELS)) && (v_mod_q < VMOD_W'(FRAME_ROWS));
  assign in_finish  = (state_q == ST_FINISH);
  assign in_second  = (state_q == ST_SECOND);
  assign issue_pair = (state_q == ST_ISSUE) && (op_q == OP_PAIR);

  `include "framebuffer_wrap_scroll_assert.svh"

  `FWS_ASSERT_ALWAYS(a_ram_port_excl, !(ram_we && ram_re), "frame RAM read and write collide")
  `FWS_ASSERT_ALWAYS(a_shift_range, shift_ok, "wrapped shift out of range")
  `FWS_ASSERT_IMPL(a_out_src, $rose(out_valid_q), $past(in_finish), "result without finished read")
  `FWS_ASSERT_IMPL(a_second_src, in_second, $past(issue_pair), "second read without pair issue")

endmodule
